// ===== rtl/core/kcd_pkg.sv =====
// ----------------------------------------------------------------------------
// kcd_pkg
// Shared types and constants for the keypad command decoder.
// ----------------------------------------------------------------------------
package kcd_pkg;

  // presets and digit entry
  localparam int unsigned PRESET_COUNT = 4;
  localparam int unsigned MAX_DIGITS   = 3;

  // keys A to D can only name four presets
  localparam int unsigned PRESET_DEPTH = (PRESET_COUNT < 4) ? PRESET_COUNT : 4;
  localparam int unsigned PIDX_W       = (PRESET_DEPTH > 1) ? $clog2(PRESET_DEPTH) : 1;
  localparam int unsigned TP_W         = 2;
  localparam int unsigned DIGIT_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ENTRY_W      = $clog2(10 ** MAX_DIGITS);

  // field widths
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned SETPOINT_W = 16;
  localparam int unsigned VALUE_W    = 10;
  localparam int unsigned SHOWN_W    = 3;
  localparam int unsigned AMOUNT_W   = 6;

  // reset values
  localparam logic [SETPOINT_W-1:0] START_SETPOINT = 16'd300;
  localparam logic                  START_SCALE    = 1'b0;
  localparam logic [VALUE_W-1:0]    DELAY_RESET    = 10'd300;
  localparam logic [VALUE_W-1:0]    VALUE_MAX      = 10'd1023;

  // opcodes
  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_ABORT = 1'b1;

  // key codes
  localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;
  localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;
  localparam logic [KEY_W-1:0] KEY_0    = 8'h30;
  localparam logic [KEY_W-1:0] KEY_1    = 8'h31;
  localparam logic [KEY_W-1:0] KEY_2    = 8'h32;
  localparam logic [KEY_W-1:0] KEY_4    = 8'h34;
  localparam logic [KEY_W-1:0] KEY_5    = 8'h35;
  localparam logic [KEY_W-1:0] KEY_7    = 8'h37;
  localparam logic [KEY_W-1:0] KEY_8    = 8'h38;
  localparam logic [KEY_W-1:0] KEY_9    = 8'h39;
  localparam logic [KEY_W-1:0] KEY_A    = 8'h41;
  localparam logic [KEY_W-1:0] KEY_C    = 8'h43;
  localparam logic [KEY_W-1:0] KEY_D    = 8'h44;

  // nudge steps
  localparam logic [AMOUNT_W-1:0] STEP_FINE   = 6'd1;
  localparam logic [AMOUNT_W-1:0] STEP_MEDIUM = 6'd10;
  localparam logic [AMOUNT_W-1:0] STEP_COARSE = 6'd50;

  // configuration port
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic        REG_DEFAULT_DELAY = 1'b0;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_MENU,
    MODE_SCALE,
    MODE_PRESET,
    MODE_DELAY
  } mode_t;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key_code;
  } item_t;

  typedef struct packed {
    logic                  status;
    logic [SETPOINT_W-1:0] temp_setpoint;
    logic                  scale_fahrenheit;
    logic                  awake;
    logic [VALUE_W-1:0]    sleep_delay;
    logic [SHOWN_W-1:0]    preset_shown;
  } result_t;

  // pipeline control between the stages
  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctrl_t;

endpackage

// ===== rtl/core/kcd_in_stage.sv =====
// ----------------------------------------------------------------------------
// kcd_in_stage
// Input register: captures one key item per transfer and holds it until
// the decode stage can move it on.
// ----------------------------------------------------------------------------
module kcd_in_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  kcd_pkg::item_t           in_item,
  input  logic                     advance,
  output kcd_pkg::pipe_ctrl_t      ctrl,
  output kcd_pkg::item_t           item
);

  logic valid;
  logic load;

  assign load     = !valid || advance;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item <= in_item;
    end
  end

  assign ctrl.valid   = valid;
  assign ctrl.advance = advance;

endmodule

// ===== rtl/core/kcd_engine.sv =====
// ----------------------------------------------------------------------------
// kcd_engine
// Menu state machine and settings registers. One held key is decoded per
// cycle unless the result side stalls, and the settings after that key go out as the result.
// ----------------------------------------------------------------------------
module kcd_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  kcd_pkg::pipe_ctrl_t               ctrl,
  input  kcd_pkg::item_t                    item,
  input  logic [kcd_pkg::VALUE_W-1:0]       default_sleep_delay,
  output kcd_pkg::result_t                  result
);

  // state
  kcd_pkg::mode_t                      mode, mode_next;
  logic [kcd_pkg::ENTRY_W-1:0]         entry_value, entry_value_next;
  logic [kcd_pkg::DIGIT_W-1:0]         digit_count, digit_count_next;
  logic [kcd_pkg::TP_W-1:0]            target_preset, target_preset_next;
  logic [kcd_pkg::PRESET_DEPTH-1:0]    preset_valid, preset_valid_next;
  logic [kcd_pkg::VALUE_W-1:0]         preset_temp [kcd_pkg::PRESET_DEPTH];
  logic [kcd_pkg::SETPOINT_W-1:0]      setpoint, setpoint_next;
  logic                                scale_flag, scale_flag_next;
  logic                                wake_flag, wake_flag_next;
  logic [kcd_pkg::VALUE_W-1:0]         delay_setting, delay_setting_next;
  logic [kcd_pkg::SHOWN_W-1:0]         shown_preset, shown_preset_next;

  // decode helpers
  logic                                fire;
  logic                                is_abort;
  logic [kcd_pkg::KEY_W-1:0]           key;
  logic                                is_digit;
  logic                                digit_room;
  logic [kcd_pkg::ENTRY_W+3:0]         acc;
  logic [kcd_pkg::ENTRY_W+9:0]         entry_wide;
  logic [kcd_pkg::VALUE_W-1:0]         entry_sat;
  logic [kcd_pkg::TP_W-1:0]            key_idx;
  logic [kcd_pkg::TP_W-1:0]            tp_sel;
  logic                                tp_ok;
  logic                                key_idx_ok;
  logic [kcd_pkg::AMOUNT_W-1:0]        amount;
  logic                                nudge_up;
  logic                                nudge_en;
  logic [kcd_pkg::SETPOINT_W:0]        sum;
  logic [kcd_pkg::SETPOINT_W-1:0]      nudged;
  logic                                pt_we;
  logic [kcd_pkg::PIDX_W-1:0]          pt_idx;
  logic                                status;

  assign fire     = ctrl.valid && ctrl.advance;
  assign is_abort = item.opcode == kcd_pkg::OP_ABORT;
  assign key      = item.key_code;
  assign is_digit = key inside {[kcd_pkg::KEY_0:kcd_pkg::KEY_9]};
  assign digit_room = 32'(digit_count) < kcd_pkg::MAX_DIGITS;

  // entry * 10 + digit as two shifts and two adds
  assign acc = ((kcd_pkg::ENTRY_W+4)'(entry_value) << 3)
             + ((kcd_pkg::ENTRY_W+4)'(entry_value) << 1)
             + (kcd_pkg::ENTRY_W+4)'(key[3:0]);

  assign entry_wide = (kcd_pkg::ENTRY_W+10)'(entry_value);
  assign entry_sat  = (entry_wide > (kcd_pkg::ENTRY_W+10)'(kcd_pkg::VALUE_MAX))
                    ? kcd_pkg::VALUE_MAX : entry_wide[kcd_pkg::VALUE_W-1:0];

  assign key_idx    = key[kcd_pkg::TP_W-1:0] - kcd_pkg::KEY_A[kcd_pkg::TP_W-1:0];
  assign key_idx_ok = 32'(key_idx) < kcd_pkg::PRESET_COUNT;
  assign tp_ok      = 32'(target_preset) < kcd_pkg::PRESET_COUNT;

  // idle nudge keys: the 1, 4, 7 column lowers, the next column (2, 5, 8) raises
  always_comb begin
    nudge_en = 1'b1;
    nudge_up = 1'b0;
    amount   = kcd_pkg::STEP_FINE;
    case (key)
      kcd_pkg::KEY_1: begin
        amount = kcd_pkg::STEP_FINE;
      end
      kcd_pkg::KEY_4: begin
        amount = kcd_pkg::STEP_MEDIUM;
      end
      kcd_pkg::KEY_7: begin
        amount = kcd_pkg::STEP_COARSE;
      end
      kcd_pkg::KEY_2: begin
        amount   = kcd_pkg::STEP_FINE;
        nudge_up = 1'b1;
      end
      kcd_pkg::KEY_5: begin
        amount   = kcd_pkg::STEP_MEDIUM;
        nudge_up = 1'b1;
      end
      kcd_pkg::KEY_8: begin
        amount   = kcd_pkg::STEP_COARSE;
        nudge_up = 1'b1;
      end
      default: begin
        nudge_en = 1'b0;
      end
    endcase
  end

  // saturating nudge
  assign sum = (kcd_pkg::SETPOINT_W+1)'(setpoint) + (kcd_pkg::SETPOINT_W+1)'(amount);
  always_comb begin
    if (nudge_up) begin
      nudged = sum[kcd_pkg::SETPOINT_W] ? '1 : sum[kcd_pkg::SETPOINT_W-1:0];
    end else if (setpoint < kcd_pkg::SETPOINT_W'(amount)) begin
      nudged = '0;
    end else begin
      nudged = setpoint - kcd_pkg::SETPOINT_W'(amount);
    end
  end

  // next state
  always_comb begin
    mode_next = mode;
    if (fire) begin
      if (is_abort) begin
        mode_next = kcd_pkg::MODE_IDLE;
      end else begin
        case (mode)
          kcd_pkg::MODE_MENU: begin
            if (key == kcd_pkg::KEY_1) begin
              mode_next = kcd_pkg::MODE_SCALE;
            end else if (key == kcd_pkg::KEY_2) begin
              mode_next = kcd_pkg::MODE_DELAY;
            end else if (key inside {[kcd_pkg::KEY_A:kcd_pkg::KEY_D]}) begin
              mode_next = kcd_pkg::MODE_PRESET;
            end else begin
              mode_next = kcd_pkg::MODE_IDLE;
            end
          end
          kcd_pkg::MODE_SCALE: begin
            mode_next = kcd_pkg::MODE_IDLE;
          end
          kcd_pkg::MODE_PRESET, kcd_pkg::MODE_DELAY: begin
            if (key == kcd_pkg::KEY_HASH || key == kcd_pkg::KEY_STAR) begin
              mode_next = kcd_pkg::MODE_IDLE;
            end
          end
          kcd_pkg::MODE_IDLE: begin
            mode_next = (key == kcd_pkg::KEY_HASH) ? kcd_pkg::MODE_MENU
                                                   : kcd_pkg::MODE_IDLE;
          end
          default: begin
            mode_next = kcd_pkg::MODE_IDLE;
          end
        endcase
      end
    end
  end

  // settings and result
  always_comb begin
    entry_value_next   = entry_value;
    digit_count_next   = digit_count;
    target_preset_next = target_preset;
    preset_valid_next  = preset_valid;
    setpoint_next      = setpoint;
    scale_flag_next    = scale_flag;
    wake_flag_next     = wake_flag;
    delay_setting_next = delay_setting;
    shown_preset_next  = shown_preset;
    pt_we              = 1'b0;
    tp_sel             = target_preset;
    status             = 1'b0;

    if (fire && !is_abort) begin
      case (mode)
        kcd_pkg::MODE_MENU: begin
          if (key == kcd_pkg::KEY_2) begin
            entry_value_next = '0;
            digit_count_next = '0;
          end else if (key inside {[kcd_pkg::KEY_A:kcd_pkg::KEY_D]}) begin
            target_preset_next = key_idx;
            entry_value_next   = '0;
            digit_count_next   = '0;
          end
        end
        kcd_pkg::MODE_SCALE: begin
          if (key == kcd_pkg::KEY_C) begin
            scale_flag_next = 1'b0;
          end else if (key == kcd_pkg::KEY_D) begin
            scale_flag_next = 1'b1;
          end
        end
        kcd_pkg::MODE_PRESET: begin
          if (is_digit && digit_room) begin
            entry_value_next = acc[kcd_pkg::ENTRY_W-1:0];
            digit_count_next = digit_count + 1'b1;
          end else if (key == kcd_pkg::KEY_HASH) begin
            if (tp_ok) begin
              preset_valid_next[pt_idx] = 1'b1;
              pt_we = 1'b1;
            end
          end else if (key == kcd_pkg::KEY_STAR) begin
            if (digit_count == '0 && tp_ok) begin
              preset_valid_next[pt_idx] = 1'b0;
            end
          end
        end
        kcd_pkg::MODE_DELAY: begin
          if (is_digit && digit_room) begin
            entry_value_next = acc[kcd_pkg::ENTRY_W-1:0];
            digit_count_next = digit_count + 1'b1;
          end else if (key == kcd_pkg::KEY_HASH) begin
            delay_setting_next = entry_sat;
          end else if (key == kcd_pkg::KEY_STAR) begin
            if (digit_count == '0) begin
              delay_setting_next = default_sleep_delay;
            end
          end
        end
        default: begin
          // idle: every key but the menu key reports no chain
          status = key != kcd_pkg::KEY_HASH;
          if (key inside {[kcd_pkg::KEY_A:kcd_pkg::KEY_D]}) begin
            tp_sel = key_idx;
            if (key_idx_ok && preset_valid[pt_idx]) begin
              setpoint_next     = kcd_pkg::SETPOINT_W'(preset_temp[pt_idx]);
              shown_preset_next = kcd_pkg::SHOWN_W'(key_idx) + 1'b1;
            end
          end else if (key == kcd_pkg::KEY_STAR) begin
            wake_flag_next = !wake_flag;
          end else if (nudge_en) begin
            setpoint_next     = nudged;
            shown_preset_next = '0;
          end
        end
      endcase
    end
  end

  assign pt_idx = tp_sel[kcd_pkg::PIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= kcd_pkg::MODE_IDLE;
      entry_value   <= '0;
      digit_count   <= '0;
      target_preset <= '0;
      preset_valid  <= '0;
      setpoint      <= kcd_pkg::START_SETPOINT;
      scale_flag    <= kcd_pkg::START_SCALE;
      wake_flag     <= 1'b1;
      delay_setting <= kcd_pkg::DELAY_RESET;
      shown_preset  <= '0;
    end else begin
      mode          <= mode_next;
      entry_value   <= entry_value_next;
      digit_count   <= digit_count_next;
      target_preset <= target_preset_next;
      preset_valid  <= preset_valid_next;
      setpoint      <= setpoint_next;
      scale_flag    <= scale_flag_next;
      wake_flag     <= wake_flag_next;
      delay_setting <= delay_setting_next;
      shown_preset  <= shown_preset_next;
    end
  end

  // preset values are only read behind their valid bits
  always_ff @(posedge clk) begin
    if (pt_we) begin
      preset_temp[pt_idx] <= entry_sat;
    end
  end

  assign result.status           = status;
  assign result.temp_setpoint    = setpoint_next;
  assign result.scale_fahrenheit = scale_flag_next;
  assign result.awake            = wake_flag_next;
  assign result.sleep_delay      = delay_setting_next;
  assign result.preset_shown     = shown_preset_next;

  a_abort_to_idle: assert property (@(posedge clk) disable iff (rst)
    fire && is_abort |=> mode == kcd_pkg::MODE_IDLE)
    else $error("abort did not return to idle");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(mode) && $stable(setpoint) && $stable(delay_setting))
    else $error("state moved without a transfer");

  a_digit_limit: assert property (@(posedge clk) disable iff (rst)
    32'(digit_count) <= kcd_pkg::MAX_DIGITS)
    else $error("digit count beyond limit");

  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    fire && status |-> mode == kcd_pkg::MODE_IDLE && !is_abort)
    else $error("status set outside idle");

  a_shown_range: assert property (@(posedge clk) disable iff (rst)
    32'(shown_preset) <= kcd_pkg::PRESET_COUNT)
    else $error("shown preset out of range");

endmodule

// ===== rtl/core/kcd_out_stage.sv =====
// ----------------------------------------------------------------------------
// kcd_out_stage
// Result register: holds one result until the consumer takes it, and
// tells the earlier stages when they may move on.
// ----------------------------------------------------------------------------
module kcd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  kcd_pkg::result_t     in_result,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kcd_pkg::result_t     out_result
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_result <= in_result;
    end
  end

endmodule

// ===== rtl/core/kcd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// kcd_apb_regs
// Configuration register file on a simple peripheral bus port.
// ----------------------------------------------------------------------------
module kcd_apb_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kcd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [kcd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [kcd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [kcd_pkg::VALUE_W-1:0]       default_sleep_delay
);

  logic sel_default;
  logic wr_en;

  // one register per 32-bit word, only word 0 is implemented
  assign sel_default = paddr[2] == kcd_pkg::REG_DEFAULT_DELAY;
  assign pready      = 1'b1;
  assign wr_en       = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_sleep_delay <= kcd_pkg::DELAY_RESET;
    end else if (wr_en && sel_default) begin
      default_sleep_delay <= pwdata[kcd_pkg::VALUE_W-1:0];
    end
  end

  assign prdata = sel_default ? kcd_pkg::CFG_DATA_W'(default_sleep_delay) : '0;

endmodule

// ===== rtl/core/keypad_command_decoder.sv =====
// ----------------------------------------------------------------------------
// keypad_command_decoder
// Keypad menu decoder for a thermostat front panel.
// ----------------------------------------------------------------------------
// Takes one key or abort per transfer and returns one result holding the
// status and all settings after that key. A new item is taken every clock
// while the result side does not stall. The item is held in the input
// register, is decoded by the single logic stage behind it and is written
// into the result register, where its result waits on the outputs until it
// is taken. A stall on the result side backs up through the input register,
// so at most two items are in flight.
// ----------------------------------------------------------------------------
module keypad_command_decoder (
  input  logic                              clk,
  input  logic                              rst,
  // key channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [kcd_pkg::KEY_W-1:0]         key_code,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              status,
  output logic [kcd_pkg::SETPOINT_W-1:0]    temp_setpoint,
  output logic                              scale_fahrenheit,
  output logic                              awake,
  output logic [kcd_pkg::VALUE_W-1:0]       sleep_delay,
  output logic [kcd_pkg::SHOWN_W-1:0]       preset_shown,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kcd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [kcd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [kcd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  kcd_pkg::item_t                in_item;
  kcd_pkg::item_t                held_item;
  kcd_pkg::pipe_ctrl_t           ctrl;
  kcd_pkg::result_t              result;
  kcd_pkg::result_t              out_result;
  logic                          advance;
  logic [kcd_pkg::VALUE_W-1:0]   default_sleep_delay;

  assign in_item.opcode   = opcode;
  assign in_item.key_code = key_code;

  kcd_apb_regs u_regs (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .default_sleep_delay (default_sleep_delay)
  );

  kcd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .ctrl     (ctrl),
    .item     (held_item)
  );

  kcd_engine u_engine (
    .clk                 (clk),
    .rst                 (rst),
    .ctrl                (ctrl),
    .item                (held_item),
    .default_sleep_delay (default_sleep_delay),
    .result              (result)
  );

  kcd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (ctrl.valid),
    .in_result  (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign status           = out_result.status;
  assign temp_setpoint    = out_result.temp_setpoint;
  assign scale_fahrenheit = out_result.scale_fahrenheit;
  assign awake            = out_result.awake;
  assign sleep_delay      = out_result.sleep_delay;
  assign preset_shown     = out_result.preset_shown;

endmodule
